@@ src/multipath_path_selector_top_defines.svh @@
// assertion macros for the multipath path selector
// used by the top level, no other dependencies
`ifndef MULTIPATH_PATH_SELECTOR_TOP_DEFINES_SVH
`define MULTIPATH_PATH_SELECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MPS_ASSERT(lbl, prop, msg)
`define MPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ src/mps_pkg.sv @@
// types and constants of the multipath path selector
// no dependencies
package mps_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_SELECT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STRAT_RR    = 2'd0,
    STRAT_RTT   = 2'd1,
    STRAT_LOSS  = 2'd2,
    STRAT_ADAPT = 2'd3
  } strategy_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_ACTIVE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_MOD,
    S_RR_RD,
    S_RR_CHK,
    S_MIN_RD,
    S_MIN_MET,
    S_MIN_CMP,
    S_DONE
  } state_e;

  localparam int unsigned MET_W      = 37;
  localparam int unsigned LOSS_SCALE = 10;
  localparam int unsigned SCORE_ONE  = 65536;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] ip_addr;
    logic [15:0] port_number;
    logic [15:0] rtt_value;
    logic [15:0] loss_value;
    logic        active_flag;
    logic [1:0]  strategy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  sel_index;
    logic [31:0] sel_ip;
    logic [15:0] sel_port;
    logic [4:0]  entry_count;
    logic        any_active;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] rtt;
    logic [15:0] loss;
    logic        active;
  } entry_t;

  // selection metric, adaptive is rtt * (1 + 10*loss) in q16
  function automatic logic [MET_W-1:0] metric(entry_t e, logic [1:0] strat);
    logic [20:0] scale;
    logic [MET_W-1:0] res;
    scale = 21'(SCORE_ONE) + 21'(e.loss) * 21'(LOSS_SCALE);
    unique case (strat)
      STRAT_RTT:  res = MET_W'(e.rtt);
      STRAT_LOSS: res = MET_W'(e.loss);
      default:    res = MET_W'(e.rtt) * MET_W'(scale);
    endcase
    return res;
  endfunction

endpackage

@@ src/mps_ifs.sv @@
// valid/ready channel interfaces of the multipath path selector
// depends on mps_pkg
interface mps_in_if;
  logic             valid;
  logic             ready;
  mps_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mps_out_if;
  logic              valid;
  logic              ready;
  mps_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/mps_mod_unit.sv @@
// bit-serial remainder of a 32-bit counter by the path count
// standalone, one quotient bit per cycle
module mps_mod_unit #(
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] rem_o
);

  logic [31:0]    sh_q, sh_d;
  logic [CNT_W:0] rem_q, rem_d;
  logic [5:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CNT_W:0] trial;

  assign trial = {rem_q[CNT_W-1:0], sh_q[31]};

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[30:0], 1'b0};
      rem_d = (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[CNT_W-1:0];

endmodule

@@ src/multipath_path_selector_top.sv @@
// top level of the multipath path selector
// depends on mps_pkg, mps_ifs, mps_mod_unit and the assertion header
`include "multipath_path_selector_top_defines.svh"

// Path table of up to MAX_PATHS entries (ip, port, rtt, loss, active) kept in
// one single-port-read memory, walked one entry at a time by a small
// sequencer. One item is taken at a time: in_i.ready is high only while the
// sequencer is idle, and a finished result sits in an output register, so
// the next item may be taken while that result still waits for its transfer.
// Add, update and remove scan for the key; a miss adds the path or reports
// full or not found, and a remove then moves each later entry down a place.
// Select lowest rtt, lowest loss or adaptive scans every stored path; round
// robin takes the rotation counter modulo the path count (one bit per cycle
// in the serial remainder unit), then examines entries from there until an
// active one. A select with no active path goes straight to the result. The
// memory read port, one entry per read with a registered read, sets the scan
// pace. No clearing pass: only entries below the path count are ever read.
// The adaptive score rtt*(65536+10*loss) is registered, then compared in the next state.
module multipath_path_selector_top #(
  parameter int unsigned MAX_PATHS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mps_in_if.sink      in_i,
  mps_out_if.source   out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_PATHS);
  localparam int unsigned CNT_W = $clog2(MAX_PATHS + 1);

  // path table
  mps_pkg::entry_t mem_q [MAX_PATHS];
  mps_pkg::entry_t rd_q;
  mps_pkg::entry_t mem_wdata;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic             mem_we;

  mps_pkg::state_e  state_q, state_d;
  mps_pkg::in_item_t item_q, item_d;
  mps_pkg::status_e status_q, status_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] act_cnt_q, act_cnt_d;
  logic [31:0]      rr_q, rr_d;
  logic [CNT_W-1:0] best_idx_q, best_idx_d;
  logic [31:0]      sel_ip_q, sel_ip_d;
  logic [15:0]      sel_port_q, sel_port_d;
  logic [mps_pkg::MET_W-1:0] met_q, met_d, best_met_q, best_met_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;
  mps_pkg::out_item_t out_q, out_d;

  logic             in_xfer, out_free, key_hit, last_entry, sel_empty;
  logic             mod_start, mod_done;
  logic [CNT_W-1:0] mod_rem, idx_inc;
  logic [31:0]      best_idx_w, total_w;

  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign key_hit    = (rd_q.ip == item_q.ip_addr) && (rd_q.port == item_q.port_number);
  assign idx_inc    = idx_q + CNT_W'(1);
  assign last_entry = (idx_inc == total_q);
  assign sel_empty  = (total_q == '0) || (act_cnt_q == '0);

  mps_mod_unit #(
    .CNT_W(CNT_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rr_q),
    .divisor_i  (total_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign mod_start = in_xfer && (in_i.data.action == mps_pkg::ACT_SELECT)
                  && (in_i.data.strategy == mps_pkg::STRAT_RR) && !sel_empty;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mps_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_i.data.action == mps_pkg::ACT_SELECT) begin
            if (sel_empty) state_d = mps_pkg::S_DONE;
            else if (in_i.data.strategy == mps_pkg::STRAT_RR) state_d = mps_pkg::S_MOD;
            else state_d = mps_pkg::S_MIN_RD;
          end else if (total_q == '0) begin
            state_d = mps_pkg::S_MISS;
          end else begin
            state_d = mps_pkg::S_FIND_RD;
          end
        end
      end
      mps_pkg::S_FIND_RD: state_d = mps_pkg::S_FIND_CHK;
      mps_pkg::S_FIND_CHK: begin
        if (key_hit) begin
          if (item_q.action == mps_pkg::ACT_REMOVE && !last_entry) begin
            state_d = mps_pkg::S_SHIFT_RD;
          end else begin
            state_d = mps_pkg::S_DONE;
          end
        end else if (last_entry) begin
          state_d = mps_pkg::S_MISS;
        end else begin
          state_d = mps_pkg::S_FIND_RD;
        end
      end
      mps_pkg::S_MISS:     state_d = mps_pkg::S_DONE;
      mps_pkg::S_SHIFT_RD: state_d = mps_pkg::S_SHIFT_WR;
      mps_pkg::S_SHIFT_WR: begin
        state_d = ((idx_inc + CNT_W'(1)) == total_q) ? mps_pkg::S_DONE
                                                      : mps_pkg::S_SHIFT_RD;
      end
      mps_pkg::S_MOD:    if (mod_done) state_d = mps_pkg::S_RR_RD;
      mps_pkg::S_RR_RD:  state_d = mps_pkg::S_RR_CHK;
      mps_pkg::S_RR_CHK: state_d = rd_q.active ? mps_pkg::S_DONE : mps_pkg::S_RR_RD;
      mps_pkg::S_MIN_RD:  state_d = mps_pkg::S_MIN_MET;
      mps_pkg::S_MIN_MET: state_d = mps_pkg::S_MIN_CMP;
      mps_pkg::S_MIN_CMP: state_d = last_entry ? mps_pkg::S_DONE : mps_pkg::S_MIN_RD;
      mps_pkg::S_DONE:    if (out_free) state_d = mps_pkg::S_IDLE;
      default:            state_d = mps_pkg::S_IDLE;
    endcase
  end

  assign total_w    = 32'(total_q);
  assign best_idx_w = 32'(best_idx_q);

  // datapath and table writes
  always_comb begin
    item_d      = item_q;
    status_d    = status_q;
    idx_d       = idx_q;
    total_d     = total_q;
    act_cnt_d   = act_cnt_q;
    rr_d        = rr_q;
    best_idx_d  = best_idx_q;
    sel_ip_d    = sel_ip_q;
    sel_port_d  = sel_port_q;
    met_d       = met_q;
    best_met_d  = best_met_q;
    found_d     = found_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[IDX_W-1:0];
    mem_wdata   = rd_q;
    mem_raddr   = idx_q[IDX_W-1:0];
    unique case (state_q)
      mps_pkg::S_IDLE: begin
        if (in_xfer) begin
          item_d     = in_i.data;
          idx_d      = '0;
          found_d    = 1'b0;
          best_idx_d = '0;
          sel_ip_d   = '0;
          sel_port_d = '0;
          status_d   = (in_i.data.action == mps_pkg::ACT_SELECT && sel_empty)
                       ? mps_pkg::ST_NO_ACTIVE : mps_pkg::ST_OK;
        end
      end
      mps_pkg::S_FIND_CHK: begin
        if (key_hit) begin
          unique case (item_q.action)
            mps_pkg::ACT_ADD: status_d = mps_pkg::ST_PRESENT;
            mps_pkg::ACT_UPDATE: begin
              mem_we         = 1'b1;
              mem_wdata.rtt  = item_q.rtt_value;
              mem_wdata.loss = item_q.loss_value;
              mem_wdata.active = item_q.active_flag;
              act_cnt_d = act_cnt_q - CNT_W'(rd_q.active) + CNT_W'(item_q.active_flag);
            end
            default: begin
              // remove: drop the count now, compaction follows if needed
              act_cnt_d = act_cnt_q - CNT_W'(rd_q.active);
              if (last_entry) total_d = total_q - CNT_W'(1);
            end
          endcase
        end else if (!last_entry) begin
          idx_d = idx_inc;
        end
      end
      mps_pkg::S_MISS: begin
        if (item_q.action == mps_pkg::ACT_ADD) begin
          if (total_q >= CNT_W'(MAX_PATHS)) begin
            status_d = mps_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = total_q[IDX_W-1:0];
            mem_wdata = '{ip: item_q.ip_addr, port: item_q.port_number,
                          rtt: '0, loss: '0, active: 1'b1};
            total_d   = total_q + CNT_W'(1);
            act_cnt_d = act_cnt_q + CNT_W'(1);
          end
        end else begin
          status_d = mps_pkg::ST_NOT_FOUND;
        end
      end
      mps_pkg::S_SHIFT_RD: mem_raddr = idx_inc[IDX_W-1:0];
      mps_pkg::S_SHIFT_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_inc;
        if ((idx_inc + CNT_W'(1)) == total_q) total_d = total_q - CNT_W'(1);
      end
      mps_pkg::S_MOD: if (mod_done) idx_d = mod_rem;
      mps_pkg::S_RR_CHK: begin
        rr_d = rr_q + 32'd1;
        if (rd_q.active) begin
          best_idx_d = idx_q;
          sel_ip_d   = rd_q.ip;
          sel_port_d = rd_q.port;
        end else begin
          // counter wrapping to zero restarts the scan at the first entry
          idx_d = (last_entry || (rr_q == '1)) ? '0 : idx_inc;
        end
      end
      mps_pkg::S_MIN_MET: met_d = mps_pkg::metric(rd_q, item_q.strategy);
      mps_pkg::S_MIN_CMP: begin
        // strict less keeps the first minimum
        if (rd_q.active && (!found_q || met_q < best_met_q)) begin
          found_d    = 1'b1;
          best_met_d = met_q;
          best_idx_d = idx_q;
          sel_ip_d   = rd_q.ip;
          sel_port_d = rd_q.port;
        end
        if (!last_entry) idx_d = idx_inc;
      end
      mps_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.sel_index   = best_idx_w[3:0];
          out_d.sel_ip      = sel_ip_q;
          out_d.sel_port    = sel_port_q;
          out_d.entry_count = total_w[4:0];
          out_d.any_active  = (act_cnt_q != '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mps_pkg::S_IDLE;
      total_q     <= '0;
      act_cnt_q   <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      act_cnt_q   <= act_cnt_d;
      rr_q        <= rr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    status_q   <= status_d;
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    sel_ip_q   <= sel_ip_d;
    sel_port_q <= sel_port_d;
    met_q      <= met_d;
    best_met_q <= best_met_d;
    found_q    <= found_d;
    out_q      <= out_d;
  end

  assign in_i.ready  = (state_q == mps_pkg::S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // table bookkeeping stays consistent
  `MPS_ASSERT(a_total_bound, total_q <= CNT_W'(MAX_PATHS), "path count above table size")
  `MPS_ASSERT(a_active_bound, act_cnt_q <= total_q, "active count above path count")
  // a failed or non-select item carries no selection
  `MPS_ASSERT(a_sel_zero,
    out_o.valid && out_o.data.status != mps_pkg::ST_OK |->
      out_o.data.sel_ip == '0 && out_o.data.sel_index == '0,
    "selection fields set on failure")
  // result register loads exactly when the sequencer leaves its last state
  `MPS_ASSERT(a_done_load,
    state_q == mps_pkg::S_DONE && out_free |=> out_valid_q && state_q == mps_pkg::S_IDLE,
    "result not loaded")

endmodule

@@ tb/multipath_path_selector_checker.sv @@
// checker for the multipath path selector: watches both channels,
// predicts each result and compares it; depends on mps_pkg and mps_ifs
module multipath_path_selector_checker #(
  parameter int unsigned MAX_PATHS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mps_in_if.sink     in_mon,
  mps_out_if.sink    out_mon,
  output int         fail_count_o,
  output int         pending_o
);
  import mps_pkg::*;

  localparam int unsigned EXP_DEPTH = 64;

  logic [31:0] tbl_ip     [MAX_PATHS];
  logic [15:0] tbl_port   [MAX_PATHS];
  logic [15:0] tbl_rtt    [MAX_PATHS];
  logic [15:0] tbl_loss   [MAX_PATHS];
  logic        tbl_active [MAX_PATHS];
  int unsigned tbl_count;
  logic [31:0] rotation;
  // expected results in arrival order, ring buffer
  out_item_t   exp_buf [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;

  assign pending_o = int'(exp_wr - exp_rd);

  function automatic int find_path(logic [31:0] ip, logic [15:0] port);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_ip[i] == ip && tbl_port[i] == port) return i;
    return -1;
  endfunction

  function automatic logic table_has_active();
    for (int i = 0; i < tbl_count; i++)
      if (tbl_active[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [36:0] path_cost(int i, logic [1:0] strat);
    logic [36:0] scale;
    if (strat == STRAT_RTT) return 37'(tbl_rtt[i]);
    if (strat == STRAT_LOSS) return 37'(tbl_loss[i]);
    scale = 37'd65536 + 37'(tbl_loss[i]) * 37'd10;
    return 37'(tbl_rtt[i]) * scale;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t   r;
    int          pos;
    int          best;
    logic [36:0] best_cost;
    logic [36:0] c;
    r = '0;
    r.status = ST_OK;
    case (action_e'(it.action))
      ACT_ADD: begin
        if (find_path(it.ip_addr, it.port_number) >= 0) r.status = ST_PRESENT;
        else if (tbl_count >= MAX_PATHS) r.status = ST_FULL;
        else begin
          tbl_ip[tbl_count] = it.ip_addr;
          tbl_port[tbl_count] = it.port_number;
          tbl_rtt[tbl_count] = '0;
          tbl_loss[tbl_count] = '0;
          tbl_active[tbl_count] = 1'b1;
          tbl_count++;
        end
      end
      ACT_REMOVE: begin
        pos = find_path(it.ip_addr, it.port_number);
        if (pos < 0) r.status = ST_NOT_FOUND;
        else begin
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_ip[i] = tbl_ip[i+1];
            tbl_port[i] = tbl_port[i+1];
            tbl_rtt[i] = tbl_rtt[i+1];
            tbl_loss[i] = tbl_loss[i+1];
            tbl_active[i] = tbl_active[i+1];
          end
          tbl_count--;
        end
      end
      ACT_UPDATE: begin
        pos = find_path(it.ip_addr, it.port_number);
        if (pos < 0) r.status = ST_NOT_FOUND;
        else begin
          tbl_rtt[pos] = it.rtt_value;
          tbl_loss[pos] = it.loss_value;
          tbl_active[pos] = it.active_flag;
        end
      end
      default: begin
        if (!table_has_active()) r.status = ST_NO_ACTIVE;
        else begin
          best = 0;
          if (it.strategy == STRAT_RR) begin
            for (int i = 0; i < tbl_count; i++) begin
              pos = int'(rotation % 32'(tbl_count));
              rotation++;
              if (tbl_active[pos]) begin
                best = pos;
                break;
              end
            end
          end else begin
            best = -1;
            best_cost = '0;
            for (int i = 0; i < tbl_count; i++) begin
              if (!tbl_active[i]) continue;
              c = path_cost(i, it.strategy);
              if (best < 0 || c < best_cost) begin
                best = i;
                best_cost = c;
              end
            end
          end
          r.sel_index = 4'(best);
          r.sel_ip = tbl_ip[best];
          r.sel_port = tbl_port[best];
        end
      end
    endcase
    r.entry_count = 5'(tbl_count);
    r.any_active = table_has_active();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      tbl_count = 0;
      rotation = '0;
      fail_count_o = 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        exp_buf[exp_wr % EXP_DEPTH] = apply_item(in_mon.data);
        exp_wr++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count_o++;
        end else begin
          want = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got.status !== want.status || got.sel_index !== want.sel_index ||
              got.sel_ip !== want.sel_ip || got.sel_port !== want.sel_port ||
              got.entry_count !== want.entry_count ||
              got.any_active !== want.any_active) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

@@ tb/multipath_path_selector_top_tb.sv @@
// testbench top for the multipath path selector: drives path table commands,
// stalls the result side and reports the verdict; depends on mps_pkg, mps_ifs,
// the block and the checker
module multipath_path_selector_top_tb;
  import mps_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  mps_in_if  cmd_ch ();
  mps_out_if res_ch ();

  multipath_path_selector_top #(.MAX_PATHS(16)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .out_o  (res_ch.source)
  );

  multipath_path_selector_checker #(.MAX_PATHS(16)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (cmd_ch.sink),
    .out_mon      (res_ch.sink),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // a small pool of keys so that adds, removes and updates hit often
  logic [31:0] key_ip   [24];
  logic [15:0] key_port [24];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // gap length: mostly zero or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver side: ready toggles with random stalls, with quiet stretches
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      stall = ($urandom_range(0, 7) == 0) ? 0 : gap_len();
      if (stall == 0) res_ch.ready <= 1'b1;
      else begin
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
        res_ch.ready <= 1'b1;
      end
    end
  end

  // one transfer on the command channel, valid stays high between items unless a random gap drops it
  task automatic send_item(in_item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= it;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(action_e a, int k, logic [1:0] strat);
    in_item_t it;
    it.action      = a;
    it.ip_addr     = key_ip[k];
    it.port_number = key_port[k];
    it.rtt_value   = 16'($urandom);
    it.loss_value  = 16'($urandom);
    it.active_flag = 1'($urandom);
    it.strategy    = strat;
    return it;
  endfunction

  initial begin
    in_item_t it;
    int       r;
    rst_ni = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    for (int k = 0; k < 24; k++) begin
      key_ip[k]   = $urandom;
      key_port[k] = 16'($urandom);
    end
    // extreme keys
    key_ip[0] = '0;          key_port[0] = '0;
    key_ip[1] = '1;          key_port[1] = '1;
    key_ip[2] = key_ip[1];   key_port[2] = 16'h0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: select, remove and update on an empty table
    send_item(make_item(ACT_SELECT, 0, STRAT_RR));
    send_item(make_item(ACT_REMOVE, 0, STRAT_RR));
    send_item(make_item(ACT_UPDATE, 1, STRAT_RR));
    // fill to full, then duplicate and overflow adds
    for (int k = 0; k < 16; k++) send_item(make_item(ACT_ADD, k, STRAT_RR));
    send_item(make_item(ACT_ADD, 3, STRAT_RR));
    send_item(make_item(ACT_ADD, 20, STRAT_RR));
    // extreme metrics, a tie, and all selection modes
    it = make_item(ACT_UPDATE, 0, STRAT_RR);
    it.rtt_value = '1; it.loss_value = '1; it.active_flag = 1'b1;
    send_item(it);
    it = make_item(ACT_UPDATE, 1, STRAT_RR);
    it.rtt_value = '0; it.loss_value = '1; it.active_flag = 1'b1;
    send_item(it);
    for (int s = 0; s < 4; s++) send_item(make_item(ACT_SELECT, 0, 2'(s)));

    // hold off until every result has come back
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    // random part: weighted toward selects and updates on live keys
    for (int n = 0; n < 1100; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25) it = make_item(ACT_ADD, $urandom_range(0, 23), 2'($urandom));
      else if (r < 38) it = make_item(ACT_REMOVE, $urandom_range(0, 23), 2'($urandom));
      else if (r < 65) it = make_item(ACT_UPDATE, $urandom_range(0, 23), 2'($urandom));
      else it = make_item(ACT_SELECT, $urandom_range(0, 23), 2'($urandom));
      // occasional unknown key and small metrics to force ties
      if ($urandom_range(0, 19) == 0) it.ip_addr = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        it.rtt_value  = 16'($urandom_range(0, 3));
        it.loss_value = 16'($urandom_range(0, 3));
      end
      send_item(it);
    end
    cmd_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+src
src/mps_pkg.sv
src/mps_ifs.sv
src/mps_mod_unit.sv
src/multipath_path_selector_top.sv
tb/multipath_path_selector_checker.sv
tb/multipath_path_selector_top_tb.sv
